>>> rtl/sm3_pkg.sv
package sm3_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumIv  = 8;
  localparam int unsigned WinLen = 16;
  localparam int unsigned Rounds = 64;

  localparam logic [WordW-1:0] T_LOW  = 32'h79CC4519;
  localparam logic [WordW-1:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]       PAD_BYTE = 8'h80;

  localparam logic [WordW-1:0] STD_IV [NumIv] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_PAD0,
    ST_PAD1,
    ST_ROUND,
    ST_OUT,
    ST_ERR
  } sm3_state_t;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [2*WordW-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WordW-1 -: WordW];
  endfunction

  function automatic word_t p0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t p1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // round constant, rotated by round mod 32
  function automatic word_t t_rot(input logic [5:0] rnd);
    word_t tj;
    tj = (rnd < 6'd16) ? T_LOW : T_HIGH;
    return rotl(tj, rnd[4:0]);
  endfunction

endpackage

>>> rtl/sm3_hash_engine.sv
// SM3 hash engine. Message bytes arrive as big-endian 32-bit words (first byte
// in bits 31:24) and are packed contiguously into 64-byte blocks; a short word
// may appear anywhere but normally only on the last word. The block takes one
// word, then places its bytes one per cycle except while a full block runs its
// rounds (valid_bytes above four counts as four); the next word waits. Each
// completed block runs 64 compression rounds on a single shared round datapath,
// one round per cycle, with the message expansion computed on the fly in a
// 16-word sliding window; the input stalls meanwhile. On the last word with
// padding selected, 0x80 and the bit length (mod 2^32, in the final four bytes)
// are appended in the PAD0 and PAD1 states, then one or two 64-round blocks run.
// The digest then leaves as eight words, one per accepted output cycle. Without
// padding, a length that is not a multiple of 64 bytes gives one error word.
// The cfg_ registers hold the starting chaining value (standard IV at reset)
// and are sampled when the first word of a message is taken.
module sm3_hash_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [sm3_pkg::WordW-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sm3_pkg::WordW-1:0]  in_data_word,
  input  logic [2:0]                 in_valid_bytes,
  input  logic                       in_last_word,
  input  logic                       in_pad_message,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sm3_pkg::WordW-1:0]  out_digest_word,
  output logic [2:0]                 out_word_index,
  output logic                       out_last_of_digest,
  output logic                       out_length_error
);
  import sm3_pkg::*;

  sm3_state_t state_r, state_nxt;
  sm3_state_t ret_r, ret_nxt;

  word_t      iv_r    [NumIv];
  word_t      chain_r [NumIv], chain_nxt [NumIv];
  word_t      v_r     [8],     v_nxt     [8];
  word_t      win_r   [WinLen], win_nxt  [WinLen];

  logic [31:0] cnt_r, cnt_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        pad_r, pad_nxt;
  logic        in_msg_r, in_msg_nxt;
  word_t       data_r, data_nxt;
  logic [2:0]  vb_r, vb_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic [2:0]  oidx_r, oidx_nxt;

  logic        in_acc, out_acc;
  logic [31:0] cnt_inc;
  logic        blk_full;
  logic [5:0]  pos;
  word_t       data_sh;
  word_t       byte_lane;
  word_t       pad_lane;
  logic        more_bytes;

  // round datapath
  word_t ff, gg, a12, ss1, ss2, tt1, tt2, wj, wpj, w_new;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign cnt_inc  = cnt_r + 32'd1;
  assign blk_full = (cnt_inc[5:0] == 6'd0);
  assign pos      = cnt_r[5:0];
  assign data_sh  = data_r << {sel_r[1:0], 3'b000};
  assign byte_lane = {24'd0, data_sh[31:24]} << {~pos[1:0], 3'b000};
  assign pad_lane  = {24'd0, PAD_BYTE} << {~pos[1:0], 3'b000};
  assign more_bytes = (sel_r < vb_r);

  always_comb begin
    wj  = win_r[0];
    wpj = win_r[0] ^ win_r[4];
    if (rnd_r < 6'd16) begin
      ff = v_r[0] ^ v_r[1] ^ v_r[2];
      gg = v_r[4] ^ v_r[5] ^ v_r[6];
    end else begin
      ff = (v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]);
      gg = (v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]);
    end
    a12   = rotl(v_r[0], 5'd12);
    ss1   = rotl(a12 + v_r[4] + t_rot(rnd_r), 5'd7);
    ss2   = ss1 ^ a12;
    tt1   = ff + v_r[3] + ss2 + wpj;
    tt2   = gg + v_r[7] + ss1 + wj;
    w_new = p1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 5'd15))
          ^ rotl(win_r[3], 5'd7) ^ win_r[10];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_BYTE;
      end
      ST_BYTE: begin
        if (more_bytes) begin
          if (blk_full) state_nxt = ST_ROUND;
        end else if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (pad_r) begin
          state_nxt = ST_PAD0;
        end else if (pos != 6'd0) begin
          state_nxt = ST_ERR;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_PAD0: begin
        state_nxt = (pos > 6'd55) ? ST_ROUND : ST_PAD1;
      end
      ST_PAD1: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_r == 6'(Rounds - 1)) state_nxt = ret_r;
      end
      ST_OUT: begin
        if (out_acc && oidx_r == 3'd7) state_nxt = ST_IDLE;
      end
      ST_ERR: begin
        if (out_acc) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ret_nxt    = ret_r;
    chain_nxt  = chain_r;
    v_nxt      = v_r;
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    rnd_nxt    = rnd_r;
    pad_nxt    = pad_r;
    in_msg_nxt = in_msg_r;
    data_nxt   = data_r;
    vb_nxt     = vb_r;
    last_nxt   = last_r;
    sel_nxt    = sel_r;
    oidx_nxt   = oidx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          data_nxt = in_data_word;
          vb_nxt   = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
          last_nxt = in_last_word;
          sel_nxt  = 3'd0;
          if (!in_msg_r) begin
            in_msg_nxt = 1'b1;
            pad_nxt    = in_pad_message;
            cnt_nxt    = 32'd0;
            chain_nxt  = iv_r;
            for (int i = 0; i < WinLen; i++) win_nxt[i] = '0;
          end
        end
      end
      ST_BYTE: begin
        if (more_bytes) begin
          win_nxt[pos[5:2]] = win_r[pos[5:2]] | byte_lane;
          cnt_nxt = cnt_inc;
          sel_nxt = sel_r + 3'd1;
          if (blk_full) begin
            v_nxt   = chain_r;
            rnd_nxt = 6'd0;
            ret_nxt = ST_BYTE;
          end
        end else if (last_r) begin
          in_msg_nxt = 1'b0;
          oidx_nxt   = 3'd0;
          if (!pad_r) begin
            cnt_nxt = 32'd0;
            for (int i = 0; i < WinLen; i++) win_nxt[i] = '0;
          end
        end
      end
      ST_PAD0: begin
        win_nxt[pos[5:2]] = win_r[pos[5:2]] | pad_lane;
        if (pos > 6'd55) begin
          v_nxt   = chain_r;
          rnd_nxt = 6'd0;
          ret_nxt = ST_PAD1;
        end
      end
      ST_PAD1: begin
        win_nxt[WinLen-1] = {cnt_r[28:0], 3'b000};
        cnt_nxt  = 32'd0;
        v_nxt    = chain_r;
        rnd_nxt  = 6'd0;
        ret_nxt  = ST_OUT;
        oidx_nxt = 3'd0;
      end
      ST_ROUND: begin
        v_nxt[3] = v_r[2];
        v_nxt[2] = rotl(v_r[1], 5'd9);
        v_nxt[1] = v_r[0];
        v_nxt[0] = tt1;
        v_nxt[7] = v_r[6];
        v_nxt[6] = rotl(v_r[5], 5'd19);
        v_nxt[5] = v_r[4];
        v_nxt[4] = p0(tt2);
        for (int i = 0; i < WinLen - 1; i++) win_nxt[i] = win_r[i+1];
        win_nxt[WinLen-1] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(Rounds - 1)) begin
          for (int i = 0; i < NumIv; i++) chain_nxt[i] = chain_r[i] ^ v_nxt[i];
          for (int i = 0; i < WinLen; i++) win_nxt[i] = '0;
        end
      end
      ST_OUT: begin
        if (out_acc) oidx_nxt = oidx_r + 3'd1;
      end
      ST_ERR: begin
      end
      default: begin
      end
    endcase
  end

  // handshake and result word
  always_comb begin
    in_stall           = (state_r != ST_IDLE);
    out_valid          = (state_r == ST_OUT) || (state_r == ST_ERR);
    out_length_error   = (state_r == ST_ERR);
    out_digest_word    = (state_r == ST_ERR) ? '0 : chain_r[oidx_r];
    out_word_index     = (state_r == ST_ERR) ? 3'd0 : oidx_r;
    out_last_of_digest = (state_r == ST_ERR) || (oidx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= ST_IDLE;
      cnt_r    <= '0;
      rnd_r    <= '0;
      pad_r    <= 1'b0;
      in_msg_r <= 1'b0;
      sel_r    <= '0;
      oidx_r   <= '0;
      iv_r     <= STD_IV;
      chain_r  <= STD_IV;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      cnt_r    <= cnt_nxt;
      rnd_r    <= rnd_nxt;
      pad_r    <= pad_nxt;
      in_msg_r <= in_msg_nxt;
      sel_r    <= sel_nxt;
      oidx_r   <= oidx_nxt;
      chain_r  <= chain_nxt;
      if (cfg_we) iv_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    win_r  <= win_nxt;
    data_r <= data_nxt;
    vb_r   <= vb_nxt;
    last_r <= last_nxt;
  end

endmodule
